/* rtl/text_terminal_char_buffer_unit_macros.svh */
// Assertion macros for the text terminal character buffer RTL.
`ifndef TEXT_TERMINAL_CHAR_BUFFER_UNIT_MACROS_SVH
`define TEXT_TERMINAL_CHAR_BUFFER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define TTCB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ttcb assertion failed");

// Condition in one cycle implies a consequence in the next cycle.
`define TTCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttcb assertion failed");

`else

`define TTCB_ASSERT(label, clk, rst, prop)
`define TTCB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/ttcb_pkg.sv */
// Package: geometry, codes and controller/datapath interface types.
package ttcb_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 60;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int CHAR_W = 8;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] CTRL_MAX   = 8'd31;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;         // capture the incoming request
    logic exec;          // carry out the captured request
    logic sweep_clear;   // write a space at the sweep counter
    logic sweep_scroll;  // move one cell up a row at the sweep counter
    logic load_out;      // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              need_scroll;
    logic              cnt_last;
  } status_t;

endpackage

/* rtl/ttcb_dp.sv */
// Datapath: screen memory, cursor, sweep counter and result register.
module ttcb_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ttcb_pkg::cmd_t               cmd,
  output ttcb_pkg::status_t            status,
  input  logic [ttcb_pkg::FUNC_W-1:0]  func,
  input  logic [ttcb_pkg::CHAR_W-1:0]  char_in,
  input  logic [ttcb_pkg::ROW_W-1:0]   read_row,
  input  logic [ttcb_pkg::COL_W-1:0]   read_col,
  output logic [ttcb_pkg::CHAR_W-1:0]  cell_value,
  output logic [ttcb_pkg::COL_W-1:0]   cursor_col,
  output logic [ttcb_pkg::ROW_W-1:0]   cursor_row,
  output logic                         scrolled
);
  import ttcb_pkg::*;

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W:0]    COLS_V    = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W:0]    ROWS_V    = (ROW_W + 1)'(ROWS);
  localparam logic [ADDR_W-1:0] CNT_LAST  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW1_ADDR = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W:0]   CELLS_V   = (ADDR_W + 1)'(CELLS);
  localparam logic [ADDR_W:0]   LOOKAHEAD = (ADDR_W + 1)'(COLUMNS + 1);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);

  logic [FUNC_W-1:0] func_q;
  logic [CHAR_W-1:0] char_q;
  logic [ROW_W-1:0]  rrow_q;
  logic [COL_W-1:0]  rcol_q;

  logic [COL_W-1:0]  col_pos;
  logic [ROW_W-1:0]  row_pos;
  logic [ADDR_W-1:0] cnt;
  logic              scrolled_q;
  logic              cell_sel_q;

  logic [CHAR_W-1:0] mem [CELLS];
  logic [CHAR_W-1:0] rdata;

  logic              is_print, is_bs, is_nl;
  logic              col_last, row_last, row_adv, need_scroll;
  logic              in_range, cnt_last, copy_src, scroll_rd_ok;
  logic [ADDR_W-1:0] cur_addr, item_addr;
  logic [ADDR_W:0]   scroll_rd;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CHAR_W-1:0] wdata;

  assign is_print    = char_q > CTRL_MAX;
  assign is_bs       = char_q == CH_BS;
  assign is_nl       = (char_q == CH_CR) || (char_q == CH_LF);
  assign col_last    = col_pos == COL_LAST;
  assign row_last    = row_pos == ROW_LAST;
  assign row_adv     = (is_print && col_last) || is_nl;
  assign need_scroll = (func_q == FUNC_PUT) && row_adv && row_last;

  assign cur_addr  = ADDR_W'(row_pos) * COLS_A + ADDR_W'(col_pos);
  assign item_addr = ADDR_W'(rrow_q) * COLS_A + ADDR_W'(rcol_q);
  assign in_range  = ({1'b0, rrow_q} < ROWS_V) && ({1'b0, rcol_q} < COLS_V);

  assign cnt_last     = cnt == CNT_LAST;
  assign copy_src     = cnt < COPY_END;
  // the scroll reads one row and one cell ahead of the write
  assign scroll_rd    = {1'b0, cnt} + LOOKAHEAD;
  assign scroll_rd_ok = scroll_rd < CELLS_V;

  assign status.func        = func_q;
  assign status.need_scroll = need_scroll;
  assign status.cnt_last    = cnt_last;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cnt;
    raddr = cnt;
    wdata = SPACE_CHAR;
    if (cmd.exec) begin
      if ((func_q == FUNC_PUT) && (is_print || is_bs)) begin
        we    = 1'b1;
        waddr = cur_addr;
        wdata = is_print ? char_q : SPACE_CHAR;
      end
      if (need_scroll) begin
        re    = 1'b1;
        raddr = ROW1_ADDR;
      end
      if ((func_q == FUNC_READ) && in_range) begin
        re    = 1'b1;
        raddr = item_addr;
      end
    end
    if (cmd.sweep_clear) begin
      we    = 1'b1;
      waddr = cnt;
      wdata = SPACE_CHAR;
    end
    if (cmd.sweep_scroll) begin
      we    = 1'b1;
      waddr = cnt;
      wdata = copy_src ? rdata : SPACE_CHAR;
      re    = scroll_rd_ok;
      raddr = scroll_rd[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= func;
      char_q <= char_in;
      rrow_q <= read_row;
      rcol_q <= read_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_pos    <= '0;
      cnt        <= '0;
      scrolled_q <= 1'b0;
      cell_sel_q <= 1'b0;
    end else begin
      if (cmd.sweep_clear || cmd.sweep_scroll) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
      if (cmd.exec) begin
        scrolled_q <= need_scroll;
        cell_sel_q <= (func_q == FUNC_READ) && in_range;
        case (func_q)
          FUNC_PUT: begin
            if (is_print) begin
              col_pos <= col_last ? '0 : col_pos + 1'b1;
            end else if (is_bs) begin
              if (col_pos != '0) col_pos <= col_pos - 1'b1;
            end else if (is_nl) begin
              col_pos <= '0;
            end
            if (row_adv && !row_last) row_pos <= row_pos + 1'b1;
          end
          FUNC_CLEAR: begin
            col_pos <= '0;
            row_pos <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cell_value <= cell_sel_q ? rdata : '0;
      cursor_col <= col_pos;
      cursor_row <= row_pos;
      scrolled   <= scrolled_q;
    end
  end

endmodule

/* rtl/ttcb_ctrl.sv */
// Controller: request sequencing, buffer sweeps and result handshake.
`include "text_terminal_char_buffer_unit_macros.svh"

module ttcb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  ttcb_pkg::status_t  status,
  output ttcb_pkg::cmd_t     cmd
);
  import ttcb_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state, state_next;
  logic       out_valid;
  logic       out_free;

  assign s_tready = state == ST_IDLE;
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.sweep_clear = 1'b1;
        if (status.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.func == FUNC_CLEAR) begin
          state_next = ST_CLEAR;
        end else if (status.need_scroll) begin
          state_next = ST_SCROLL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_clear = 1'b1;
        if (status.cnt_last) state_next = ST_DONE;
      end
      ST_SCROLL: begin
        cmd.sweep_scroll = 1'b1;
        if (status.cnt_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TTCB_ASSERT(a_cmd_onehot, clk, rst, $onehot0({cmd.latch, cmd.exec, cmd.sweep_clear, cmd.sweep_scroll, cmd.load_out}))
  `TTCB_ASSERT(a_no_accept_in_sweep, clk, rst, !((cmd.sweep_clear || cmd.sweep_scroll) && s_tready))
  `TTCB_ASSERT_NEXT(a_load_shows_result, clk, rst, cmd.load_out, out_valid)

endmodule

/* rtl/text_terminal_char_buffer_unit.sv */
// Top level: character-cell text terminal with scrolling screen buffer.
//
// A 60 x 80 byte screen buffer with a cursor. One request is worked at a time.
// A put-character request that does not scroll, a read and an idle selector
// pass through the execute and done states to the result register; a
// put-character that runs off the last row, and a clear, sweep the screen
// memory one cell per cycle (a scroll does one read and one write a cycle).
// After reset the memory is swept to spaces before the first request is
// accepted. A result held in the output register is kept until taken; a new
// request is accepted meanwhile and waits at its end for the register to
// free up.
module text_terminal_char_buffer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_in[7:0], read_row[13:8], read_col[20:14], zero
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // cell_value[7:0], cursor_col[14:8], cursor_row[20:15], zero
  output logic        m_tuser    // scrolled
);
  import ttcb_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic [CHAR_W-1:0] cell_value;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;

  ttcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ttcb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .func       (s_tuser),
    .char_in    (s_tdata[7:0]),
    .read_row   (s_tdata[13:8]),
    .read_col   (s_tdata[20:14]),
    .cell_value (cell_value),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (m_tuser)
  );

  assign m_tdata = {3'b000, cursor_row, cursor_col, cell_value};

endmodule
